>>> src/haversine_distance_core_assert.svh
// Assertion helpers for the distance core.
`ifndef HAVERSINE_DISTANCE_CORE_ASSERT_SVH
`define HAVERSINE_DISTANCE_CORE_ASSERT_SVH

// Checked only out of reset.
`define HVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define HVD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/hvd_pkg.sv
package hvd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 30;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 25;

  localparam int XW     = FRAC_BITS + 3;
  localparam int HW     = 34;
  localparam int RMAG_W = 31;
  localparam int RT_W   = FRAC_BITS + 2;
  localparam int REM_W  = FRAC_BITS + 5;
  localparam int VW     = 2 * FRAC_BITS + 2;

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  localparam logic signed [HW-1:0] HALF_PI_UNITS = 34'sd1800000000;
  localparam logic signed [HW-1:0] PI_UNITS      = 34'sd3600000000;
  localparam logic signed [HW-1:0] TWO_PI_UNITS  = 34'sd7200000000;

  localparam logic [127:0] RAD_FULL = ({64'd0, PI_Q61} << 16) / 128'd3600000000;
  localparam int K_W  = 47;
  localparam int KL_W = 24;
  localparam int KH_W = K_W - KL_W;
  localparam logic [K_W-1:0]  RAD_Q77 = RAD_FULL[K_W-1:0];
  localparam logic [KH_W-1:0] K_HI    = RAD_Q77[K_W-1:KL_W];
  localparam logic [KL_W-1:0] K_LO    = RAD_Q77[KL_W-1:0];
  localparam int Z_SHIFT = 77 - FRAC_BITS;
  localparam int PP_W    = RMAG_W + K_W + 1;

  localparam int R_W  = 39;
  localparam int RL_W = 20;
  localparam int RH_W = R_W - RL_W;
  localparam logic [R_W-1:0]  EARTH_RADIUS_Q16 = 39'd417647660948;
  localparam logic [RH_W-1:0] R_HI = EARTH_RADIUS_Q16[R_W-1:RL_W];
  localparam logic [RL_W-1:0] R_LO = EARTH_RADIUS_Q16[RL_W-1:0];
  localparam int D_SHIFT = FRAC_BITS + 16;
  localparam int DS_W    = XW + R_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_HIGH = 25'd20021000;

  localparam int SC_LAT   = CORDIC_STAGES + 4;
  localparam int TERM_LAT = 4;
  localparam int SQ_LAT   = FRAC_BITS + 2;
  localparam int VEC_LAT  = CORDIC_STAGES + 2;
  localparam int TOT_LAT  = 1 + SC_LAT + TERM_LAT + SQ_LAT + VEC_LAT;

  function automatic logic [63:0] round_to_f(input logic [63:0] v, input int from_bits);
    int s;
    s = from_bits - FRAC_BITS;
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] atan_f(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      return round_to_f((PI_Q61 + 64'd2) >> 2, 61);
    end
    for (int k = 0; k < 62; k++) begin
      e = 61 - (2 * k + 1) * i;
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return round_to_f(acc, 61);
  endfunction

  function automatic logic [63:0] inv_gain_f();
    logic [127:0] p;
    logic [127:0] f;
    logic [127:0] prod;
    int e;
    p = 128'd1 << 61;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      f = '0;
      for (int k = 0; k < 63; k++) begin
        e = 62 - 2 * i * k;
        if (e >= 0) begin
          if (k % 2 == 1) begin
            f = f - (128'd1 << e);
          end else begin
            f = f + (128'd1 << e);
          end
        end
      end
      prod = p * f;
      p = (prod + (128'd1 << 61)) >> 62;
      if (p > (128'd1 << 62)) begin
        p = 128'd1 << 62;
      end
    end
    return round_to_f(p[63:0], 62);
  endfunction

  localparam logic signed [XW-1:0] INV_GAIN_SQ = XW'(inv_gain_f());
  localparam logic signed [XW-1:0] ONE_X       = XW'(64'd1 << FRAC_BITS);

  function automatic logic signed [XW-1:0] mul_rnd(input logic signed [XW-1:0] a,
                                                   input logic signed [XW-1:0] b);
    logic neg;
    logic [XW-1:0] ua;
    logic [XW-1:0] ub;
    logic [2*XW-1:0] p;
    logic [XW-1:0] r;
    neg = a[XW-1] ^ b[XW-1];
    ua = a[XW-1] ? XW'(-a) : XW'(a);
    ub = b[XW-1] ? XW'(-b) : XW'(b);
    p = {{XW{1'b0}}, ua} * {{XW{1'b0}}, ub};
    p = (p + ((2*XW)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    r = p[XW-1:0];
    return neg ? $signed(XW'(-r)) : $signed(r);
  endfunction

endpackage

>>> src/hvd_in_if.sv
interface hvd_in_if;
  import hvd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] origin_lat;
  logic signed [LON_W-1:0] origin_lon;
  logic signed [LAT_W-1:0] dest_lat;
  logic signed [LON_W-1:0] dest_lon;
  modport source (output valid, output origin_lat, output origin_lon, output dest_lat,
                  output dest_lon, input ready);
  modport sink (input valid, input origin_lat, input origin_lon, input dest_lat,
                input dest_lon, output ready);
endinterface

>>> src/hvd_out_if.sv
interface hvd_out_if;
  import hvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_m;
  modport source (output valid, output distance_m, input ready);
  modport sink (input valid, input distance_m, output ready);
endinterface

>>> src/hvd_sincos.sv
module hvd_sincos (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [hvd_pkg::HW-1:0] ang_i,
  output logic signed [hvd_pkg::XW-1:0] cos_o,
  output logic signed [hvd_pkg::XW-1:0] sin_o
);
  import hvd_pkg::*;

  localparam logic [PP_W-1:0] Z_RND = PP_W'(1) << (Z_SHIFT - 1);

  logic signed [HW-1:0] r1, r2, r3;
  logic                 flip_nxt;
  logic [RMAG_W-1:0]    mag_nxt;

  logic [RMAG_W-1:0]      mag_r;
  logic                   neg0_r, flip0_r;
  logic [RMAG_W+KH_W-1:0] pph_r;
  logic [RMAG_W+KL_W-1:0] ppl_r;
  logic                   neg1_r, flip1_r;
  logic signed [XW-1:0]   z0_r;
  logic                   flip2_r;

  logic [PP_W-1:0]      psum, psh;
  logic signed [XW-1:0] zmag;

  logic signed [XW-1:0] x_r [0:CORDIC_STAGES-1];
  logic signed [XW-1:0] y_r [0:CORDIC_STAGES-1];
  logic signed [XW-1:0] z_r [0:CORDIC_STAGES-1];
  logic                 f_r [0:CORDIC_STAGES-1];
  logic signed [XW-1:0] cos_r, sin_r;

  always_comb begin
    r1 = (ang_i >= PI_UNITS) ? ang_i - TWO_PI_UNITS : ang_i;
    r2 = (r1 < -PI_UNITS) ? r1 + TWO_PI_UNITS : r1;
    r3 = r2;
    flip_nxt = 1'b0;
    if (r2 > HALF_PI_UNITS) begin
      r3 = r2 - PI_UNITS;
      flip_nxt = 1'b1;
    end else if (r2 < -HALF_PI_UNITS) begin
      r3 = r2 + PI_UNITS;
      flip_nxt = 1'b1;
    end
    mag_nxt = r3[HW-1] ? RMAG_W'(-r3) : RMAG_W'(r3);
  end

  always_comb begin
    psum = PP_W'({pph_r, {KL_W{1'b0}}}) + PP_W'(ppl_r) + Z_RND;
    psh  = psum >> Z_SHIFT;
    zmag = $signed(psh[XW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      neg0_r  <= r3[HW-1];
      flip0_r <= flip_nxt;
      pph_r   <= mag_r * K_HI;
      ppl_r   <= mag_r * K_LO;
      neg1_r  <= neg0_r;
      flip1_r <= flip0_r;
      z0_r    <= neg1_r ? -zmag : zmag;
      flip2_r <= flip1_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [XW-1:0] ATAN_I = XW'(atan_f(i));
    logic signed [XW-1:0] xi, yi, zi;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = ONE_X;
      assign yi = '0;
      assign zi = z0_r;
      assign fi = flip2_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign fi = f_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_I;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_I;
        end
        f_r[i] <= fi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= f_r[CORDIC_STAGES-1] ? -x_r[CORDIC_STAGES-1] : x_r[CORDIC_STAGES-1];
      sin_r <= f_r[CORDIC_STAGES-1] ? -y_r[CORDIC_STAGES-1] : y_r[CORDIC_STAGES-1];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

>>> src/hvd_term.sv
module hvd_term (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [hvd_pkg::XW-1:0] sd_i,
  input  logic signed [hvd_pkg::XW-1:0] c1_i,
  input  logic signed [hvd_pkg::XW-1:0] c2_i,
  input  logic signed [hvd_pkg::XW-1:0] sl_i,
  output logic [hvd_pkg::FRAC_BITS:0]   a_o,
  output logic [hvd_pkg::FRAC_BITS:0]   na_o
);
  import hvd_pkg::*;

  localparam int AW = XW + 1;
  localparam logic [FRAC_BITS:0]    ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0]  ONE_A = AW'(ONE_F);

  logic signed [XW-1:0] sdd_r, c12_r, sll_r;
  logic signed [XW-1:0] t1_r, cc_r, sl2_r;
  logic signed [XW-1:0] t1b_r, t2_r;
  logic signed [AW-1:0] asum;
  logic [FRAC_BITS:0]   a_nxt;
  logic [FRAC_BITS:0]   a_r, na_r;

  always_comb begin
    asum = AW'(t1b_r) + AW'(t2_r);
    if (asum < 0) begin
      a_nxt = '0;
    end else if (asum > ONE_A) begin
      a_nxt = ONE_F;
    end else begin
      a_nxt = asum[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdd_r <= mul_rnd(sd_i, sd_i);
      c12_r <= mul_rnd(c1_i, c2_i);
      sll_r <= mul_rnd(sl_i, sl_i);
      t1_r  <= mul_rnd(sdd_r, INV_GAIN_SQ);
      cc_r  <= mul_rnd(c12_r, INV_GAIN_SQ);
      sl2_r <= mul_rnd(sll_r, INV_GAIN_SQ);
      t1b_r <= t1_r;
      t2_r  <= mul_rnd(sl2_r, cc_r);
      a_r   <= a_nxt;
      na_r  <= ONE_F - a_nxt;
    end
  end

  assign a_o  = a_r;
  assign na_o = na_r;

endmodule

>>> src/hvd_sqrt.sv
module hvd_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hvd_pkg::FRAC_BITS:0]  rad_i,
  output logic [hvd_pkg::RT_W-1:0]     root_o
);
  import hvd_pkg::*;

  logic [VW-1:0]    v_r    [0:FRAC_BITS-1];
  logic [REM_W-1:0] rem_r  [0:FRAC_BITS];
  logic [RT_W-1:0]  root_r [0:FRAC_BITS];
  logic [RT_W-1:0]  out_r;

  for (genvar j = 0; j <= FRAC_BITS; j++) begin : g_it
    localparam int P = FRAC_BITS - j;
    logic [VW-1:0]    vi;
    logic [REM_W-1:0] remi, rems, trial;
    logic [RT_W-1:0]  rooti;
    if (j == 0) begin : g_first
      assign vi    = VW'({rad_i, {FRAC_BITS{1'b0}}});
      assign remi  = '0;
      assign rooti = '0;
    end else begin : g_next
      assign vi    = v_r[j-1];
      assign remi  = rem_r[j-1];
      assign rooti = root_r[j-1];
    end
    assign rems  = {remi[REM_W-3:0], vi[2*P+1:2*P]};
    assign trial = REM_W'({rooti, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (rems >= trial) begin
          rem_r[j]  <= rems - trial;
          root_r[j] <= {rooti[RT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rems;
          root_r[j] <= {rooti[RT_W-2:0], 1'b0};
        end
      end
    end
    if (j < FRAC_BITS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[j] <= vi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= (rem_r[FRAC_BITS] > REM_W'(root_r[FRAC_BITS])) ?
               root_r[FRAC_BITS] + RT_W'(1) : root_r[FRAC_BITS];
    end
  end

  assign root_o = out_r;

endmodule

>>> src/hvd_vec.sv
module hvd_vec (
  input  logic                        clk,
  input  logic                        en,
  input  logic [hvd_pkg::RT_W-1:0]    ys_i,
  input  logic [hvd_pkg::RT_W-1:0]    xs_i,
  output logic [hvd_pkg::DIST_W-1:0]  distance_o
);
  import hvd_pkg::*;

  localparam logic [DS_W-1:0] D_RND = DS_W'(1) << (D_SHIFT - 1);

  logic signed [XW-1:0] x_r [0:CORDIC_STAGES-1];
  logic signed [XW-1:0] y_r [0:CORDIC_STAGES-1];
  logic signed [XW-1:0] z_r [0:CORDIC_STAGES-1];

  logic signed [XW-1:0] zc;
  logic [XW-1:0]        dz;
  logic [XW+RH_W-1:0]   pph_r;
  logic [XW+RL_W-1:0]   ppl_r;
  logic [DS_W-1:0]      dsum, dsh;
  logic [DIST_W-1:0]    dist_nxt, dist_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic signed [XW-1:0] ATAN_I = XW'(atan_f(i));
    logic signed [XW-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = XW'(xs_i);
      assign yi = XW'(ys_i);
      assign zi = '0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi >= 0) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_I;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_I;
        end
      end
    end
  end

  always_comb begin
    zc = (z_r[CORDIC_STAGES-1] < 0) ? '0 : z_r[CORDIC_STAGES-1];
    dz = {zc[XW-2:0], 1'b0};
  end

  always_comb begin
    dsum = DS_W'({pph_r, {RL_W{1'b0}}}) + DS_W'(ppl_r) + D_RND;
    dsh  = dsum >> D_SHIFT;
    dist_nxt = (dsh > DS_W'(DIST_MAX)) ? DIST_MAX : dsh[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pph_r  <= dz * R_HI;
      ppl_r  <= dz * R_LO;
      dist_r <= dist_nxt;
    end
  end

  assign distance_o = dist_r;

endmodule

>>> src/haversine_distance_core.sv
// Great-circle distance core.
// in_ch carries one point pair per beat: origin_lat, origin_lon, dest_lat,
// dest_lon, signed, in units of 1e-7 degree. out_ch returns one beat per
// input beat with distance_m, the distance in whole meters, rounded.
// Beats leave in the order they arrive.
// The path from accept to result runs through the two 24-step CORDIC
// chains and the 31-step square root, one register per step.
// Throughput: one beat per cycle outside stalls; every stage is registered.
// Stall: the whole pipeline holds while out_ch.valid is high and
// out_ch.ready is low; in_ch.ready drops for that cycle only. Bubbles move
// forward while the output is empty, so no beat is lost or repeated.
// Reset: rst_n low at a clock edge clears every valid bit; payload
// registers keep stale values that are never shown.
`include "haversine_distance_core_assert.svh"

module haversine_distance_core (
  input logic      clk,
  input logic      rst_n,
  hvd_in_if.sink   in_ch,
  hvd_out_if.source out_ch
);
  import hvd_pkg::*;

  logic                 adv;
  logic [TOT_LAT-1:0]   vld_r;
  logic signed [HW-1:0] dlat_r, dlon_r, lat1_r, lat2_r;

  logic signed [XW-1:0] sd, sl, c1, c2;
  logic [FRAC_BITS:0]   a, na;
  logic [RT_W-1:0]      ys, xs;
  logic [DIST_W-1:0]    dist_m;

  assign adv          = !vld_r[TOT_LAT-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[TOT_LAT-1];
  assign out_ch.distance_m = dist_m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlat_r <= HW'(in_ch.dest_lat) - HW'(in_ch.origin_lat);
      dlon_r <= HW'(in_ch.dest_lon) - HW'(in_ch.origin_lon);
      lat1_r <= HW'(in_ch.origin_lat) <<< 1;
      lat2_r <= HW'(in_ch.dest_lat) <<< 1;
    end
  end

  hvd_sincos u_sc_dlat (.clk(clk), .en(adv), .ang_i(dlat_r), .cos_o(), .sin_o(sd));
  hvd_sincos u_sc_dlon (.clk(clk), .en(adv), .ang_i(dlon_r), .cos_o(), .sin_o(sl));
  hvd_sincos u_sc_lat1 (.clk(clk), .en(adv), .ang_i(lat1_r), .cos_o(c1), .sin_o());
  hvd_sincos u_sc_lat2 (.clk(clk), .en(adv), .ang_i(lat2_r), .cos_o(c2), .sin_o());

  hvd_term u_term (
    .clk(clk), .en(adv), .sd_i(sd), .c1_i(c1), .c2_i(c2), .sl_i(sl),
    .a_o(a), .na_o(na)
  );

  hvd_sqrt u_sqrt_a  (.clk(clk), .en(adv), .rad_i(a),  .root_o(ys));
  hvd_sqrt u_sqrt_na (.clk(clk), .en(adv), .rad_i(na), .root_o(xs));

  hvd_vec u_vec (.clk(clk), .en(adv), .ys_i(ys), .xs_i(xs), .distance_o(dist_m));

  `HVD_ASSERT(a_stall_hold, !adv |=> $stable(vld_r), "valid bits moved during a stall")
  `HVD_ASSERT(a_dist_range, out_ch.valid |-> out_ch.distance_m <= DIST_HIGH, "distance beyond half circumference")
  `HVD_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_ch.valid, "result valid right after reset")

endmodule

>>> verif/haversine_distance_core_tb.sv
`timescale 1ns / 100ps

module haversine_distance_core_tb;
  import hvd_pkg::*;

  localparam longint HALF_PI_U = 64'sd1800000000;
  localparam longint PI_U      = 64'sd3600000000;
  localparam longint TWO_PI_U  = 64'sd7200000000;
  localparam longint RADIUS_Q16 = 64'sd417647660948;
  localparam int     IDLE_LIMIT = 4000;
  localparam int     N_RANDOM   = 600;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
  } pair_t;

  typedef struct {
    pair_t  pt;
    longint fixed_m;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hvd_in_if  in_if ();
  hvd_out_if out_if ();

  haversine_distance_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint            atan_tab [CORDIC_STAGES];
  longint            inv_gain;
  longint            rad_k;
  logic [DIST_W-1:0] dist_q [$];
  logic              in_fire = 1'b0;
  logic              out_fire = 1'b0;
  logic [DIST_W-1:0] out_dist_s;
  logic              burst = 1'b0;
  int                errors = 0;
  int                pairs_sent = 0;
  int                dists_seen = 0;
  int                idle_cycles = 0;
  longint            max_seen = 0;

  function automatic longint mul_rs(longint a, longint b, int s);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] p;
    logic [63:0]  r;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = p + (128'd1 << (s - 1));
    r = 64'(p >> s);
    if (r > (64'd1 << 62)) r = 64'd1 << 62;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic longint rnd_f(logic [63:0] v, int from_bits);
    int s;
    s = from_bits - FRAC_BITS;
    return $signed((v + (64'd1 << (s - 1))) >> s);
  endfunction

  function automatic longint atan_calc(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    if (i == 0) return rnd_f((PI_Q61 + 64'd2) >> 2, 61);
    for (int k = 0; 61 - (2 * k + 1) * i >= 0; k++) begin
      e = 61 - (2 * k + 1) * i;
      term = (64'd1 << e) / 64'(2 * k + 1);
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return rnd_f(acc, 61);
  endfunction

  function automatic longint gain_calc();
    longint p;
    longint f;
    p = 64'sd1 << 61;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      f = 0;
      for (int k = 0; 62 - 2 * i * k >= 0; k++) begin
        if (k % 2 == 1) f = f - (64'sd1 << (62 - 2 * i * k));
        else f = f + (64'sd1 << (62 - 2 * i * k));
      end
      p = mul_rs(p, f, 62);
    end
    return rnd_f(p, 62);
  endfunction

  function automatic void rotate(longint h, output longint cs, output longint sn);
    longint r;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    logic   flip;
    flip = 1'b0;
    r = h % TWO_PI_U;
    if (r >= PI_U) r = r - TWO_PI_U;
    if (r < -PI_U) r = r + TWO_PI_U;
    if (r > HALF_PI_U) begin
      r = r - PI_U;
      flip = 1'b1;
    end else if (r < -HALF_PI_U) begin
      r = r + PI_U;
      flip = 1'b1;
    end
    z = mul_rs(r, rad_k, 77 - FRAC_BITS);
    x = 64'sd1 << FRAC_BITS;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint root_f(logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    int          k;
    rem = '0;
    root = '0;
    for (int p = FRAC_BITS; p >= 0; p--) begin
      k = 2 * p - FRAC_BITS;
      rem = (rem << 2) | {62'd0, (k + 1 >= 0) ? a[k + 1] : 1'b0, (k >= 0) ? a[k] : 1'b0};
      root = root << 1;
      trial = (root << 1) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    if (rem > root) root = root + 64'd1;
    return $signed(root);
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_m(pair_t pt);
    longint one;
    longint la1, lo1, la2, lo2;
    longint c1, s1, c2, s2, cd, sd, cl, sl, t1, t2, cc, a, x, y, z, d, xs, ys;
    one = 64'sd1 << FRAC_BITS;
    la1 = pt.lat1; lo1 = pt.lon1; la2 = pt.lat2; lo2 = pt.lon2;
    rotate(la2 - la1, cd, sd);
    rotate(lo2 - lo1, cl, sl);
    rotate(2 * la1, c1, s1);
    rotate(2 * la2, c2, s2);
    t1 = mul_rs(mul_rs(sd, sd, FRAC_BITS), inv_gain, FRAC_BITS);
    cc = mul_rs(mul_rs(c1, c2, FRAC_BITS), inv_gain, FRAC_BITS);
    t2 = mul_rs(mul_rs(mul_rs(sl, sl, FRAC_BITS), inv_gain, FRAC_BITS), cc, FRAC_BITS);
    a = t1 + t2;
    if (a < 0) a = 0;
    if (a > one) a = one;
    y = root_f(a);
    x = root_f(one - a);
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab[i];
      end
    end
    if (z < 0) z = 0;
    d = mul_rs(2 * z, RADIUS_Q16, FRAC_BITS + 16);
    if (d < 0) d = 0;
    if (d > 64'sd33554431) d = 64'sd33554431;
    return DIST_W'(d);
  endfunction

  always @(negedge clk) begin
    in_fire <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    out_dist_s <= out_if.distance_m;
  end

  always @(posedge clk) begin
    if (out_fire) begin
      dists_seen <= dists_seen + 1;
      if (out_dist_s > max_seen) max_seen <= out_dist_s;
      if (dist_q.size() == 0) begin
        $display("%0t: distance %0d with no pair pending", $time, out_dist_s);
        errors <= errors + 1;
      end else begin
        if (out_dist_s !== dist_q[0]) begin
          $display("%0t: distance_m expected %0d actual %0d", $time, dist_q[0], out_dist_s);
          errors <= errors + 1;
        end
        void'(dist_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("haversine_distance_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_fire);
    end
  end

  task automatic send_pair(pair_t pt, longint fixed_m);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.origin_lat <= pt.lat1;
    in_if.origin_lon <= pt.lon1;
    in_if.dest_lat <= pt.lat2;
    in_if.dest_lon <= pt.lon2;
    do @(posedge clk); while (!in_fire);
    dist_q.push_back(fixed_m >= 0 ? DIST_W'(fixed_m) : great_circle_m(pt));
    pairs_sent++;
  endtask

  function automatic pair_t rand_pair();
    pair_t pt;
    int    mode;
    mode = $urandom_range(0, 9);
    pt.lat1 = LAT_W'(longint'($urandom_range(0, 1800000000)) - 900000000);
    pt.lon1 = LON_W'(longint'($urandom_range(0, 3600000000)) - 1800000000);
    pt.lat2 = LAT_W'(longint'($urandom_range(0, 1800000000)) - 900000000);
    pt.lon2 = LON_W'(longint'($urandom_range(0, 3600000000)) - 1800000000);
    if (mode == 0) begin
      pt.lat1 = LAT_W'($urandom); pt.lon1 = $urandom;
      pt.lat2 = LAT_W'($urandom); pt.lon2 = $urandom;
    end else if (mode == 1) begin
      pt.lat2 = LAT_W'(longint'(pt.lat1) + longint'($urandom_range(0, 2000)) - 1000);
      pt.lon2 = LON_W'(longint'(pt.lon1) + longint'($urandom_range(0, 2000)) - 1000);
    end else if (mode == 2) begin
      pt.lat2 = -pt.lat1;
      pt.lon2 = pt.lon1 + (pt.lon1 < 0 ? 1800000000 : -1800000000);
    end
    return pt;
  endfunction

  row_t rows [$];

  initial begin
    pair_t pt;
    in_if.valid = 1'b0;
    in_if.origin_lat = '0;
    in_if.origin_lon = '0;
    in_if.dest_lat = '0;
    in_if.dest_lon = '0;
    for (int i = 0; i < CORDIC_STAGES; i++) atan_tab[i] = atan_calc(i);
    inv_gain = gain_calc();
    rad_k = $signed((PI_Q61 / 64'd3600000000) * 64'd65536
                    + ((PI_Q61 % 64'd3600000000) * 64'd65536) / 64'd3600000000);
    rows = '{
      '{'{31'sd0, 32'sd0, 31'sd0, 32'sd0}, 0},
      '{'{31'sd900000000, 32'sd1800000000, 31'sd900000000, 32'sd1800000000}, 0},
      '{'{-31'sd900000000, -32'sd1800000000, -31'sd900000000, -32'sd1800000000}, 0},
      '{'{31'sd123456789, -32'sd987654321, 31'sd123456789, -32'sd987654321}, 0},
      '{'{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0}, -1},
      '{'{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000}, -1},
      '{'{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000}, -1},
      '{'{31'sd0, 32'sd900000000, 31'sd0, -32'sd900000000}, -1},
      '{'{31'sd450000000, 32'sd0, -31'sd450000000, 32'sd1800000000}, -1},
      '{'{31'sd900000000, 32'sd0, 31'sd900000000, 32'sd1800000000}, -1},
      '{'{31'sd0, 32'sd0, 31'sd1, 32'sd1}, -1},
      '{'{31'sd0, 32'sd0, 31'sd0, 32'sd1}, -1},
      '{'{-31'sd1073741824, -32'sd2147483648, 31'sd1073741823, 32'sd2147483647}, -1},
      '{'{31'sd1073741823, 32'sd2147483647, 31'sd1073741823, -32'sd2147483648}, -1},
      '{'{31'sd1000000000, 32'sd0, 31'sd1000000000, 32'sd0}, -1},
      '{'{31'sd1000000000, 32'sd0, -31'sd1000000000, 32'sd1800000000}, -1},
      '{'{31'sd1073741823, 32'sd100, 31'sd1073741823, 32'sd1800000100}, -1},
      '{'{31'sd515000000, -32'sd1200000, 31'sd407000000, -32'sd740000000}, -1},
      '{'{-31'sd339000000, 32'sd1512000000, 31'sd516000000, -32'sd12000}, -1}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst = 1'b1;
    foreach (rows[i]) send_pair(rows[i].pt, rows[i].fixed_m);
    burst = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      burst = (n % 150) >= 120;
      pt = rand_pair();
      send_pair(pt, -1);
    end
    burst = 1'b0;
    in_if.valid <= 1'b0;
    wait (dist_q.size() == 0);
    repeat (TOT_LAT + 20) @(posedge clk);
    $display("%0d point pairs sent, %0d distances checked, largest %0d m",
             pairs_sent, dists_seen, max_seen);
    $display("covered same points, poles, antipodes, full-width coordinates, bursts and stalls");
    if (errors == 0) begin
      $display("haversine_distance_core_tb: clean");
    end else begin
      $display("haversine_distance_core_tb: errors");
    end
    $finish;
  end

endmodule
